// ===== rtl/acs_pkg.sv =====
// Shared types, codes and the microcode ROM for the accumulator machine.
// No dependencies; imported by acs_seq and accumulator_cpu_step.
package acs_pkg;

    localparam int ADDR_W     = 8;
    localparam int ADDR_SPACE = 1 << ADDR_W;
    localparam int OPC_W      = 4;
    localparam int WORD_W     = OPC_W + ADDR_W;
    localparam int ACC_W      = 16;
    localparam int STATUS_W   = 3;

    // Item operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SETPC = 2'd1;
    localparam logic [1:0] OP_EXEC  = 2'd2;

    // Instruction opcodes
    localparam logic [OPC_W-1:0] OPC_HALT  = 4'd0;
    localparam logic [OPC_W-1:0] OPC_LOAD  = 4'd1;
    localparam logic [OPC_W-1:0] OPC_STORE = 4'd2;
    localparam logic [OPC_W-1:0] OPC_ADD   = 4'd3;
    localparam logic [OPC_W-1:0] OPC_SUB   = 4'd4;
    localparam logic [OPC_W-1:0] OPC_JL    = 4'd5;
    localparam logic [OPC_W-1:0] OPC_JMP   = 4'd6;
    localparam logic [OPC_W-1:0] OPC_PRINT = 4'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRINT   = 3'd4;

    localparam logic signed [ACC_W-1:0] JL_LIMIT = 16'sd10;
    localparam logic [ADDR_W-1:0]       HALT_PC  = 8'd14;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [OPC_W-1:0]  opcode_in;
        logic [ADDR_W-1:0] operand_in;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [OPC_W-1:0]         executed_opcode;
        logic [ADDR_W-1:0]        print_address;
        logic [ADDR_W-1:0]        print_value;
        logic signed [ACC_W-1:0]  accumulator;
        logic [ADDR_W-1:0]        program_counter;
        logic                     halted;
    } rsp_t;

    // Microcode fields
    typedef enum logic [1:0] {RD_NONE, RD_PC, RD_ARG} rd_sel_t;
    typedef enum logic [1:0] {ACT_NONE, ACT_WRITE, ACT_SETPC, ACT_EXEC} act_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_DISPATCH, SEQ_IDLE} seq_t;

    typedef struct packed {
        logic    ready;    // take a command item this step
        rd_sel_t rd;       // memory read address select
        logic    ir_load;  // capture fetched instruction
        act_t    act;      // datapath action
        logic    done;     // load the result register
        seq_t    seq;      // sequencing
    } ctrl_t;

    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_IDLE  = 3'd0;
    localparam upc_t U_WRITE = 3'd1;
    localparam upc_t U_SETPC = 3'd2;
    localparam upc_t U_FETCH = 3'd3;
    localparam upc_t U_EXEC  = 3'd4;
    localparam upc_t U_NOP   = 3'd5;

    function automatic ctrl_t ucode_rom(input upc_t a);
        ctrl_t w;
        w = '{ready: 1'b0, rd: RD_NONE, ir_load: 1'b0, act: ACT_NONE,
              done: 1'b0, seq: SEQ_IDLE};
        case (a)
            U_IDLE:
            begin
                w.ready = 1'b1;
                w.rd    = RD_PC;
                w.seq   = SEQ_DISPATCH;
            end
            U_WRITE:
            begin
                w.act  = ACT_WRITE;
                w.done = 1'b1;
            end
            U_SETPC:
            begin
                w.act  = ACT_SETPC;
                w.done = 1'b1;
            end
            U_FETCH:
            begin
                w.rd      = RD_ARG;
                w.ir_load = 1'b1;
                w.seq     = SEQ_NEXT;
            end
            U_EXEC:
            begin
                w.act  = ACT_EXEC;
                w.done = 1'b1;
            end
            U_NOP:
            begin
                w.done = 1'b1;
            end
            default:
            begin
                w.seq = SEQ_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch(input logic [1:0] op);
        upc_t t;
        case (op)
            OP_WRITE: t = U_WRITE;
            OP_SETPC: t = U_SETPC;
            OP_EXEC:  t = U_FETCH;
            default:  t = U_NOP;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/acs_seq.sv =====
// Microcode sequencer: step counter, control ROM and dispatch jump.
// Depends on acs_pkg.
module acs_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic [1:0]     operation,
    input  logic           out_free,
    output acs_pkg::ctrl_t ctrl
);
    import acs_pkg::*;

    upc_t  upc_reg;
    upc_t  upc_next;
    ctrl_t word;
    logic  hold;

    always_comb
    begin
        word = ucode_rom(upc_reg);
        // a finishing step waits while the result register is occupied
        hold = word.done && !out_free;
        ctrl = word;
        if (hold)
        begin
            ctrl.act  = ACT_NONE;
            ctrl.done = 1'b0;
        end
        case (word.seq)
            SEQ_NEXT:     upc_next = upc_reg + 1'b1;
            SEQ_DISPATCH: upc_next = cmd_valid ? dispatch(operation) : upc_reg;
            SEQ_IDLE:     upc_next = hold ? upc_reg : U_IDLE;
            default:      upc_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/accumulator_cpu_step.sv =====
// Top level of the accumulator machine: datapath, program memory, result register.
// Depends on acs_pkg and acs_seq.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one item: write a memory word,
//   set the program counter, or execute the instruction at the program counter.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result item per
//   command item, in order.
// Steps after the accepting edge, up to the edge that loads the result register:
//   write / set pc / unused operation: the finishing step U_WRITE, U_SETPC or U_NOP
//   execute: U_FETCH then U_EXEC; an execute is an
//   instruction fetch then a dependent operand read on the one synchronous
//   memory port, then write-back.
//   cmd_ready is high only in the idle step; one item is worked on at a time.
// Stall: a finished result sits in the result register; the next command is
//   taken meanwhile and runs up to its final step, where it waits for rsp_ready.
// Reset: accumulator, pc and halt flag clear; every memory word reads as zero
//   via per-word valid bits, so no clearing pass is needed.
module accumulator_cpu_step #(
    parameter int MEM_WORDS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  acs_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output acs_pkg::rsp_t rsp
);
    import acs_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    // Address space to memory index (address modulo MEM_WORDS), built at elaboration.
    function automatic logic [ADDR_SPACE-1:0][AW-1:0] build_idx_tab();
        logic [ADDR_SPACE-1:0][AW-1:0] t;
        for (int i = 0; i < ADDR_SPACE; i++)
        begin
            t[i] = AW'(i % MEM_WORDS);
        end
        return t;
    endfunction

    localparam logic [ADDR_SPACE-1:0][AW-1:0] IDX_TAB = build_idx_tab();

    ctrl_t ctrl;
    logic  out_free;

    // Architectural state
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [ADDR_W-1:0]       pc_reg;
    logic [ADDR_W-1:0]       pc_next;
    logic                    halt_reg;
    logic                    halt_next;

    // Program memory with per-word valid bits
    logic [WORD_W-1:0]    mem_array [MEM_WORDS];
    logic [MEM_WORDS-1:0] valid_reg;
    logic [WORD_W-1:0]    rdata_reg;
    logic                 rvalid_reg;
    logic [WORD_W-1:0]    rd_word;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;

    // Item and instruction holding registers
    cmd_t              item_reg;
    logic [WORD_W-1:0] ir_reg;
    logic [OPC_W-1:0]  ir_opc;
    logic [ADDR_W-1:0] ir_arg;
    logic [ADDR_W-1:0] pc_inc;

    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;

    assign out_free = !rsp_valid_reg || rsp_ready;

    acs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .operation (cmd.operation),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    assign cmd_ready = ctrl.ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Words never written read as zero.
    assign rd_word = rvalid_reg ? rdata_reg : '0;
    assign ir_opc  = ir_reg[WORD_W-1:ADDR_W];
    assign ir_arg  = ir_reg[ADDR_W-1:0];
    assign pc_inc  = pc_reg + 1'b1;

    // Read port: pc while idle (speculative fetch), fetched operand in the fetch step.
    assign mem_re    = (ctrl.rd != RD_NONE);
    assign mem_raddr = (ctrl.rd == RD_PC) ? IDX_TAB[pc_reg] : IDX_TAB[rd_word[ADDR_W-1:0]];

    always_comb
    begin
        acc_next  = acc_reg;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        mem_we    = 1'b0;
        mem_waddr = IDX_TAB[item_reg.address];
        mem_wdata = {item_reg.opcode_in, item_reg.operand_in};
        rsp_next  = '0;
        rsp_next.status = ST_DONE;
        case (ctrl.act)
            ACT_WRITE:
            begin
                mem_we = 1'b1;
            end
            ACT_SETPC:
            begin
                pc_next = item_reg.address;
            end
            ACT_EXEC:
            begin
                if (halt_reg)
                begin
                    rsp_next.status = ST_HALTED;
                end
                else
                begin
                    rsp_next.executed_opcode = ir_opc;
                    // rd_word holds mem[arg] here
                    case (ir_opc)
                        OPC_HALT:
                        begin
                            if (ir_arg == '0)
                            begin
                                pc_next         = HALT_PC;
                                halt_next       = 1'b1;
                                rsp_next.status = ST_HALT;
                            end
                            else
                            begin
                                rsp_next.status = ST_INVALID;
                            end
                        end
                        OPC_LOAD:
                        begin
                            acc_next = {{(ACC_W-ADDR_W){1'b0}}, rd_word[ADDR_W-1:0]};
                            pc_next  = pc_inc;
                        end
                        OPC_STORE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = IDX_TAB[ir_arg];
                            // keep the target word's opcode
                            mem_wdata = {rd_word[WORD_W-1:ADDR_W], acc_reg[ADDR_W-1:0]};
                            pc_next   = pc_inc;
                        end
                        OPC_ADD:
                        begin
                            acc_next = acc_reg + {{(ACC_W-ADDR_W){1'b0}}, rd_word[ADDR_W-1:0]};
                            pc_next  = pc_inc;
                        end
                        OPC_SUB:
                        begin
                            acc_next = acc_reg - {{(ACC_W-ADDR_W){1'b0}}, rd_word[ADDR_W-1:0]};
                            pc_next  = pc_inc;
                        end
                        OPC_JL:
                        begin
                            pc_next = (acc_reg < JL_LIMIT) ? ir_arg : pc_inc;
                        end
                        OPC_JMP:
                        begin
                            pc_next = ir_arg;
                        end
                        OPC_PRINT:
                        begin
                            rsp_next.status        = ST_PRINT;
                            rsp_next.print_address = ir_arg;
                            rsp_next.print_value   = rd_word[ADDR_W-1:0];
                            pc_next                = pc_inc;
                        end
                        default:
                        begin
                            rsp_next.status = ST_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                // unused operation: report state unchanged
            end
        endcase
        rsp_next.accumulator     = acc_next;
        rsp_next.program_counter = pc_next;
        rsp_next.halted          = halt_next;
    end

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_array[mem_raddr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd;
        end
        if (ctrl.ir_load)
        begin
            ir_reg <= rd_word;
        end
        if (ctrl.done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rvalid_reg <= valid_reg[mem_raddr];
            end
            if (ctrl.done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // Only reset clears the halt flag.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    // Halting parks the program counter.
    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halt_reg) |-> (pc_reg == HALT_PC))
        else $error("halt without pc parked");

    // One item in flight: no command taken right after one is taken.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while busy");

    // A result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !ctrl.done)
        else $error("result register overwritten");
`endif

endmodule
